/* hw/rtl/pssl_pkg.sv */
// Shared widths, constants and register indexes for the segment speed limit block.
package pssl_pkg;
	localparam int unsigned AxesDefault = 6;
	localparam int unsigned AngleW = 32;
	localparam int unsigned QW = 32;
	localparam int unsigned ShareW = 17;
	localparam int unsigned CountW = 10;
	localparam int unsigned CfgIdxW = 2;
	localparam logic [QW-1:0] Sat32 = '1;
	localparam logic [ShareW-1:0] OneQ16 = 17'h10000;
	localparam logic [CountW-1:0] CountMax = '1;

	typedef enum logic [CfgIdxW-1:0] {
		REG_VEL_LIMIT  = 2'd0,
		REG_ACC_LIMIT  = 2'd1,
		REG_VEL_STEP   = 2'd2,
		REG_HALF_COUNT = 2'd3
	} cfg_reg_t;
endpackage

/* hw/rtl/pssl_serial_div.sv */
// Restoring divider, one quotient bit per cycle, used for every quotient of the block.
module pssl_serial_div #(
	parameter int unsigned NumW = 48,
	parameter int unsigned DenW = 34
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NumW-1:0] num,
	input  logic [DenW-1:0] den,
	output logic            done,
	output logic [NumW-1:0] quot
);
	localparam int unsigned CntW = $clog2(NumW + 1);
	localparam logic [CntW-1:0] Steps = CntW'(NumW);

	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic [NumW-1:0] quot_q;
	logic [DenW:0]   rem_q;
	logic [DenW-1:0] den_q;
	logic [DenW:0]   trial;
	logic [DenW:0]   diff;

	assign trial = {rem_q[DenW-1:0], quot_q[NumW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= Steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			if (!diff[DenW]) begin
				rem_q  <= diff;
				quot_q <= {quot_q[NumW-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign quot = quot_q;
endmodule

/* hw/rtl/path_segment_speed_limits_top.sv */
// Top level of the segment speed limit block: sequencer around serial arithmetic units.
// Usage:
//   s_axis carries one joint waypoint per transaction: tdata holds the AXES angles
//   (signed Q16.16, axis 0 lowest), tlast marks the final waypoint of a path.
//   m_axis carries one result per segment: tdata holds length, velocity limit,
//   acceleration limit and corner limit (Q16.16 each), tlast marks the path end.
//   The user writes configuration (cfg_we/cfg_index/cfg_data) while idle, not enforced.
// Sequencing:
//   One waypoint at a time. A dropped or first waypoint passes only through the compare
//   step. For a segment, squared terms come from a bit-serial multiply with an
//   accumulate per axis, the root runs one result bit per cycle, and the share and
//   the three quotients per axis go through one shared restoring divider, each
//   division being 48 steps plus a start and a capture.
// Reset:
//   arst_n clears the path state, loads the register defaults, and empties the
//   output register.
// Stall:
//   The result sits in the output register until m_axis_tready; the next waypoint
//   is taken meanwhile, its result waits in the last step and holds s_axis_tready low.
module path_segment_speed_limits_top #(
	parameter int unsigned AXES = pssl_pkg::AxesDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// fields from lowest bit: angle_axis0 .. angle_axis(AXES-1)
	input  logic [AXES*pssl_pkg::AngleW-1:0] s_axis_tdata,
	input  logic                     s_axis_tlast,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// fields from lowest bit: segment_length, segment_velocity_limit,
	// segment_acceleration_limit, corner_velocity_limit
	output logic [4*pssl_pkg::QW-1:0] m_axis_tdata,
	output logic                     m_axis_tlast,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	input  logic                     cfg_we,
	input  logic [pssl_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [pssl_pkg::QW-1:0]  cfg_data
);
	import pssl_pkg::*;

	localparam int unsigned AxW = (AXES > 1) ? $clog2(AXES) : 1;
	localparam logic [AxW-1:0] LastAx = AxW'(AXES - 1);
	localparam int unsigned MagW = 33;
	localparam int unsigned SumW = 72;
	localparam int unsigned DivNW = 48;
	localparam int unsigned DivDW = 34;

	typedef enum logic [3:0] {
		S_IDLE, S_CMP, S_SQ, S_SQACC, S_ROOT, S_SHARE, S_VEL, S_ACC, S_COR, S_OUT
	} state_t;

	// configuration
	logic [QW-1:0]     vel_lim_q, acc_lim_q, vel_step_q;
	logic [CountW-1:0] half_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_lim_q  <= 32'h0001_0000;
			acc_lim_q  <= 32'h0001_0000;
			vel_step_q <= 32'h0001_0000;
			half_cnt_q <= CountW'(100);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_VEL_LIMIT:  vel_lim_q  <= cfg_data;
				REG_ACC_LIMIT:  acc_lim_q  <= cfg_data;
				REG_VEL_STEP:   vel_step_q <= cfg_data;
				REG_HALF_COUNT: half_cnt_q <= cfg_data[CountW-1:0];
				default: ;
			endcase
		end
	end

	state_t            state_q;
	logic [AngleW-1:0] prev_pt_q [AXES];
	logic [AngleW-1:0] pt_q [AXES];
	logic [ShareW-1:0] prev_sh_q [AXES];
	logic [ShareW-1:0] sh_q [AXES];
	logic              last_q, pt_valid_q, sh_valid_q;
	logic [CountW-1:0] seg_cnt_q;
	logic [AxW-1:0]    ax_q;
	logic [5:0]        bit_q;
	logic [SumW-1:0]   sum_q;
	logic              ovf_q;
	logic [MagW-1:0]   mag_q;      // multiplier shifted out bit by bit
	logic [2*MagW-1:0] prod_q;     // partial product, shifted right each step
	logic [SumW-1:0]   rad_q, root_q, rem_q;
	logic [QW-1:0]     len_q, vlim_q, alim_q, cor_q;
	logic              div_start_q;
	logic              out_full_q;

	// per-axis magnitude of the current axis
	logic signed [AngleW:0] dcur;
	logic [MagW-1:0]        mcur;
	assign dcur = $signed({pt_q[ax_q][AngleW-1], pt_q[ax_q]})
		- $signed({prev_pt_q[ax_q][AngleW-1], prev_pt_q[ax_q]});
	assign mcur = dcur[AngleW] ? MagW'(-dcur) : MagW'(dcur);

	// upper half of the product plus the multiplicand when the multiplier bit is set
	logic [MagW:0] sq_hi;
	assign sq_hi = prod_q[2*MagW-1:QW] + (mag_q[0] ? {1'b0, mcur} : '0);

	// square root, one result bit per cycle over two radicand bits
	logic [SumW-1:0] rtrial, rrem;
	assign rrem   = {rem_q[SumW-3:0], rad_q[SumW-1:SumW-2]};
	assign rtrial = {root_q[SumW-3:0], 2'b01};

	// shared divider
	logic [DivNW-1:0] div_num;
	logic [DivDW-1:0] div_den;
	logic             div_done;
	logic [DivNW-1:0] div_quot;
	logic             halve;
	logic [ShareW-1:0] sh_cur, sh_diff;

	assign halve   = seg_cnt_q < half_cnt_q;
	assign sh_cur  = sh_q[ax_q];
	assign sh_diff = (sh_cur > prev_sh_q[ax_q]) ? sh_cur - prev_sh_q[ax_q]
		: prev_sh_q[ax_q] - sh_cur;

	always_comb begin
		div_num = '0;
		div_den = '0;
		unique case (state_q)
			S_SHARE: begin
				div_num = {mcur[31:0], 16'h0};
				div_den = DivDW'(len_q);
			end
			S_VEL: begin
				div_num = {vel_lim_q, 16'h0};
				div_den = DivDW'({sh_cur, 1'b0}) >> !halve;
			end
			S_ACC: begin
				div_num = {acc_lim_q, 16'h0};
				div_den = DivDW'({sh_cur, 1'b0}) >> !halve;
			end
			S_COR: begin
				div_num = {vel_step_q, 16'h0};
				div_den = DivDW'(sh_diff);
			end
			default: ;
		endcase
	end

	pssl_serial_div #(.NumW(DivNW), .DenW(DivDW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_q),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	logic [QW-1:0] qsat;
	assign qsat = (div_den == '0 || div_quot[DivNW-1:QW] != '0) ? Sat32 : div_quot[QW-1:0];

	logic same;
	always_comb begin
		same = 1'b1;
		for (int a = 0; a < AXES; a++)
			if (pt_q[a] != prev_pt_q[a]) same = 1'b0;
	end

	// load the output register when it is empty or being drained this cycle
	logic out_load;
	assign out_load = (state_q == S_OUT) && (!out_full_q || m_axis_tready);

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pt_valid_q  <= 1'b0;
			sh_valid_q  <= 1'b0;
			seg_cnt_q   <= '0;
			out_full_q  <= 1'b0;
			div_start_q <= 1'b0;
			for (int a = 0; a < AXES; a++) begin
				prev_pt_q[a] <= '0;
				prev_sh_q[a] <= '0;
			end
		end else begin
			div_start_q <= 1'b0;
			priority if (out_load) out_full_q <= 1'b1;
			else if (m_axis_tready) out_full_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (s_axis_tvalid) begin
					for (int a = 0; a < AXES; a++)
						pt_q[a] <= s_axis_tdata[a*AngleW +: AngleW];
					last_q  <= s_axis_tlast;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (!pt_valid_q || same) begin
						// first waypoint loads the point; a duplicate is dropped
						for (int a = 0; a < AXES; a++) prev_pt_q[a] <= pt_q[a];
						pt_valid_q <= !last_q;
						if (last_q) begin
							sh_valid_q <= 1'b0;
							seg_cnt_q  <= '0;
						end
						state_q <= S_IDLE;
					end else begin
						ax_q    <= '0;
						sum_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_SQ;
						bit_q   <= '0;
						prod_q  <= '0;
						mag_q   <= '0;
					end
				end
				S_SQ: begin
					// shift-add square of |d|, one multiplier bit per cycle
					if (bit_q == 6'd0) begin
						mag_q  <= mcur;
						prod_q <= '0;
						bit_q  <= 6'd1;
						if (mcur[32]) ovf_q <= 1'b1;
					end else begin
						mag_q  <= mag_q >> 1;
						prod_q <= {1'b0, sq_hi, prod_q[QW-1:1]};
						if (bit_q == 6'd32) state_q <= S_SQACC;
						bit_q <= bit_q + 6'd1;
					end
				end
				S_SQACC: begin
					if (!mcur[32]) begin
						if ((SumW'(prod_q) + sum_q) > SumW'(64'hFFFF_FFFF_FFFF_FFFF))
							ovf_q <= 1'b1;
						sum_q <= sum_q + SumW'(prod_q);
					end
					bit_q <= '0;
					if (ax_q == LastAx) begin
						state_q <= S_ROOT;
						rad_q   <= sum_q + (mcur[32] ? '0 : SumW'(prod_q));
						root_q  <= '0;
						rem_q   <= '0;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= S_SQ;
					end
				end
				S_ROOT: begin
					rad_q <= rad_q << 2;
					if (rrem >= rtrial) begin
						rem_q  <= rrem - rtrial;
						root_q <= {root_q[SumW-2:0], 1'b1};
					end else begin
						rem_q  <= rrem;
						root_q <= {root_q[SumW-2:0], 1'b0};
					end
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'd35) begin
						state_q <= S_SHARE;
						ax_q    <= '0;
						bit_q   <= '0;
						vlim_q  <= Sat32;
						alim_q  <= Sat32;
						cor_q   <= Sat32;
					end
				end
				S_SHARE: begin
					if (bit_q == 6'd0) begin
						len_q <= (ovf_q || root_q[SumW-1:QW] != '0) ? Sat32 : root_q[QW-1:0];
						bit_q <= 6'd1;
					end else if (bit_q == 6'd1) begin
						div_start_q <= 1'b1;
						bit_q       <= 6'd2;
					end else if (div_done) begin
						sh_q[ax_q] <= (div_quot > DivNW'(OneQ16)) ? OneQ16 : div_quot[ShareW-1:0];
						bit_q      <= 6'd1;
						if (ax_q == LastAx) begin
							ax_q    <= '0;
							state_q <= S_VEL;
						end else ax_q <= ax_q + 1'b1;
					end
				end
				S_VEL, S_ACC, S_COR: begin
					if (bit_q == 6'd1) begin
						div_start_q <= 1'b1;
						bit_q       <= 6'd2;
					end else if (div_done) begin
						bit_q <= 6'd1;
						if (state_q == S_VEL && qsat < vlim_q) vlim_q <= qsat;
						if (state_q == S_ACC && qsat < alim_q) alim_q <= qsat;
						if (state_q == S_COR && qsat < cor_q)  cor_q  <= qsat;
						if (ax_q == LastAx) begin
							ax_q <= '0;
							priority if (state_q == S_VEL) state_q <= S_ACC;
							else if (state_q == S_ACC) state_q <= S_COR;
							else state_q <= S_OUT;
						end else ax_q <= ax_q + 1'b1;
					end
				end
				S_OUT: if (out_load) begin
					m_axis_tdata <= {(sh_valid_q ? cor_q : QW'(0)), alim_q, vlim_q, len_q};
					m_axis_tlast <= last_q;
					for (int a = 0; a < AXES; a++) begin
						prev_pt_q[a] <= pt_q[a];
						prev_sh_q[a] <= sh_q[a];
					end
					if (last_q) begin
						pt_valid_q <= 1'b0;
						sh_valid_q <= 1'b0;
						seg_cnt_q  <= '0;
					end else begin
						sh_valid_q <= 1'b1;
						if (seg_cnt_q != CountMax) seg_cnt_q <= seg_cnt_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
